// ===== hw/rtl/u8dec_pkg.sv =====
// Shared types and constants for the UTF-8 to UTF-16 stream decoder.
package u8dec_pkg;

    // Closing status codes, also used as the halt cause.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TRUNC   = 2'd1,
        ST_INVALID = 2'd2,
        ST_LIMIT   = 2'd3
    } status_t;

    localparam int unsigned UNIT_W     = 16;
    localparam int unsigned CP_W       = 21;
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [UNIT_W-1:0] MAX_UNITS_RESET = 16'hFFFF;
    localparam logic [UNIT_W-1:0] HI_SURR_BASE    = 16'hD800;
    localparam logic [UNIT_W-1:0] LO_SURR_BASE    = 16'hDC00;
    localparam logic [19:0]       SUPP_OFFSET     = 20'h10000;

    // One result transaction.
    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic              unit_valid;
        logic              string_done;
        status_t           status;
        logic              last_of_run;
    } result_t;

    // Results produced by one decode step, handed to the result queue.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

// ===== hw/rtl/utf8_to_utf16_stream_decoder_unit.sv =====
// UTF-8 to UTF-16 stream decoder: top level.
//
// Input channel s_*: one UTF-8 byte per transaction, s_tlast on the last
// byte of a string. Output channel m_*: one UTF-16 code unit or a status
// per transaction. A 4-byte form yields a surrogate pair (two transactions);
// the transaction that closes a string has m_tlast high and carries the
// status (ok, truncated, invalid lead, unit limit). A closing status with no
// unit comes with unit_valid low and a zero code unit.
// cfg_wr_en/cfg_wr_data set the per-string unit limit; write only when idle.
//
// A byte accepted into the input register is decoded from there, and its
// results are written into the result queue, whose head is offered on m_*.
// Throughput: one byte per cycle while results are taken and the queue has
// room; a pair is two results, so the result queue's single read port sets
// the rate to one result per cycle.
// A byte sits in the input register until the 4-entry result queue has room
// for two results; a stalled receiver fills the queue and then drops s_tready.
// Reset: limit returns to 65535, string state clears, queue empties.
module utf8_to_utf16_stream_decoder_unit
    import u8dec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] code_unit
    output logic [3:0]  m_tuser,   // [0] unit_valid, [2:1] status, [3] last_of_run
    output logic        m_tlast    // string_done
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_eos_reg;
    logic       s_accept;
    logic       step;
    logic       room;
    logic       not_empty;
    push_t      push;
    result_t    head;

    // input stage drains whenever the queue can absorb a pair
    assign step     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || step;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_tdata;
            in_eos_reg  <= s_tlast;
        end
    end

    u8dec_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .step          (step),
        .data_byte     (in_byte_reg),
        .end_of_string (in_eos_reg),
        .push          (push)
    );

    u8dec_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (m_tvalid && m_tready),
        .room      (room),
        .not_empty (not_empty),
        .head      (head)
    );

    assign m_tvalid = not_empty;
    assign m_tdata  = head.code_unit;
    assign m_tuser  = {head.last_of_run, head.status, head.unit_valid};
    assign m_tlast  = head.string_done;

`ifndef NO_ASSERTIONS
    // a result without a unit only ever closes a string
    a_novalid_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> m_tlast)
        else $error("unit-less result does not close the string");

    // only the high half of a surrogate pair is not the last of its run
    a_pair_first: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[3]) |-> (m_tuser[0] && !m_tlast &&
                                       (m_tdata[15:10] == 6'b110110)))
        else $error("non-final result is not a high surrogate");

    // status is zero unless the result closes the string
    a_status_on_close: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tuser[2:1] == 2'd0))
        else $error("status on a non-closing result");

    // input held back only while a byte waits for queue space
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && !room))
        else $error("input stalled without a waiting byte");
`endif

endmodule

// ===== hw/rtl/u8dec_core.sv =====
// Decode step: string state, unit limit register and result formation.
module u8dec_core
    import u8dec_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [UNIT_W-1:0] cfg_wr_data,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  logic              end_of_string,
    output push_t             push
);

    logic [UNIT_W-1:0] max_units_reg;
    logic [CP_W-1:0]   partial_reg,  partial_next;
    logic [1:0]        pending_reg,  pending_next;
    logic              four_reg,     four_next;
    logic [UNIT_W-1:0] emitted_reg,  emitted_next;
    logic              halted_reg,   halted_next;
    status_t           cause_reg,    cause_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_units_reg <= MAX_UNITS_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_units_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        logic              halt_v;
        status_t           cause_v;
        logic [CP_W-1:0]   partial_v;
        logic [1:0]        pending_v;
        logic              four_v;
        logic [1:0]        nu;
        logic [UNIT_W-1:0] u0;
        logic [UNIT_W-1:0] u1;
        logic [CP_W-1:0]   shifted;
        logic [19:0]       cp;
        logic [UNIT_W:0]   sum2;
        logic [UNIT_W-1:0] emitted_v;
        status_t           close_st;
        result_t           r0;
        result_t           r1;

        halt_v    = halted_reg;
        cause_v   = cause_reg;
        partial_v = partial_reg;
        pending_v = pending_reg;
        four_v    = four_reg;
        nu        = 2'd0;
        u0        = '0;
        u1        = '0;
        shifted   = {partial_reg[CP_W-7:0], data_byte[5:0]};
        cp        = shifted[19:0] - SUPP_OFFSET;
        sum2      = {1'b0, emitted_reg} + 17'd2;

        // limit check comes before the byte is looked at
        if (!halt_v && (emitted_reg >= max_units_reg))
        begin
            halt_v  = 1'b1;
            cause_v = ST_LIMIT;
        end

        if (!halt_v)
        begin
            if (pending_reg != 2'd0)
            begin
                partial_v = shifted;
                pending_v = pending_reg - 2'd1;
                if (pending_v == 2'd0)
                begin
                    if (four_reg)
                    begin
                        // pair never written partially
                        if (sum2 > {1'b0, max_units_reg})
                        begin
                            halt_v  = 1'b1;
                            cause_v = ST_LIMIT;
                        end
                        else
                        begin
                            u0 = HI_SURR_BASE | {6'd0, cp[19:10]};
                            u1 = LO_SURR_BASE | {6'd0, cp[9:0]};
                            nu = 2'd2;
                        end
                    end
                    else
                    begin
                        u0 = shifted[UNIT_W-1:0];
                        nu = 2'd1;
                    end
                    four_v    = 1'b0;
                    partial_v = '0;
                end
            end
            else
            begin
                case (data_byte) inside
                    [8'h00:8'h7F]:
                    begin
                        u0 = {8'd0, data_byte};
                        nu = 2'd1;
                    end
                    [8'hC0:8'hDF]:
                    begin
                        partial_v = {16'd0, data_byte[4:0]};
                        pending_v = 2'd1;
                    end
                    [8'hE0:8'hEF]:
                    begin
                        partial_v = {17'd0, data_byte[3:0]};
                        pending_v = 2'd2;
                    end
                    [8'hF0:8'hF7]:
                    begin
                        partial_v = {18'd0, data_byte[2:0]};
                        pending_v = 2'd3;
                        four_v    = 1'b1;
                    end
                    default:
                    begin
                        halt_v  = 1'b1;
                        cause_v = ST_INVALID;
                    end
                endcase
            end
        end

        emitted_v = emitted_reg + {14'd0, nu};

        if (halt_v)
        begin
            close_st = cause_v;
        end
        else if (pending_v != 2'd0)
        begin
            close_st = ST_TRUNC;
        end
        else
        begin
            close_st = ST_OK;
        end

        r0 = '{code_unit: u0, unit_valid: (nu != 2'd0), string_done: 1'b0,
               status: ST_OK, last_of_run: (nu != 2'd2)};
        r1 = '{code_unit: u1, unit_valid: 1'b1, string_done: 1'b0,
               status: ST_OK, last_of_run: 1'b1};
        if (end_of_string)
        begin
            if (nu == 2'd2)
            begin
                r1.string_done = 1'b1;
                r1.status      = close_st;
            end
            else
            begin
                r0.string_done = 1'b1;
                r0.status      = close_st;
            end
        end

        push.first  = r0;
        push.second = r1;
        if (!step)
        begin
            push.count = 2'd0;
        end
        else if ((nu == 2'd0) && end_of_string)
        begin
            push.count = 2'd1;
        end
        else
        begin
            push.count = nu;
        end

        partial_next = partial_reg;
        pending_next = pending_reg;
        four_next    = four_reg;
        emitted_next = emitted_reg;
        halted_next  = halted_reg;
        cause_next   = cause_reg;
        if (step)
        begin
            if (end_of_string)
            begin
                partial_next = '0;
                pending_next = 2'd0;
                four_next    = 1'b0;
                emitted_next = '0;
                halted_next  = 1'b0;
                cause_next   = ST_OK;
            end
            else
            begin
                partial_next = partial_v;
                pending_next = pending_v;
                four_next    = four_v;
                emitted_next = emitted_v;
                halted_next  = halt_v;
                cause_next   = cause_v;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            pending_reg <= 2'd0;
            four_reg    <= 1'b0;
            emitted_reg <= '0;
            halted_reg  <= 1'b0;
            cause_reg   <= ST_OK;
        end
        else
        begin
            partial_reg <= partial_next;
            pending_reg <= pending_next;
            four_reg    <= four_next;
            emitted_reg <= emitted_next;
            halted_reg  <= halted_next;
            cause_reg   <= cause_next;
        end
    end

endmodule

// ===== hw/rtl/u8dec_fifo.sv =====
// Small result queue: takes up to two results per cycle, gives one.
module u8dec_fifo
    import u8dec_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    input  logic    pop,
    output logic    room,
    output logic    not_empty,
    output result_t head
);

    result_t             mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0]  count_reg,  count_next;
    logic [FIFO_AW-1:0]  wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    assign not_empty    = (count_reg != '0);
    // room for a full pair
    assign room         = (count_reg <= FIFO_CW'(FIFO_DEPTH - 2));
    assign head         = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push.count);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        count_next  = count_reg + FIFO_CW'(push.count) - FIFO_CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_plus1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== tb/utf16_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the UTF-8 to UTF-16 decoder: predicts every result transaction and compares.
module utf16_result_checker
    import u8dec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [3:0]  m_tuser,
    input  logic        m_tlast,
    output int          mismatches,
    output int          outstanding
);

    logic [15:0]     unit_limit;
    logic [CP_W-1:0] cp_acc;
    logic [1:0]      cont_left;
    logic            four_form;
    logic [15:0]     units_out;
    logic            halted;
    status_t         halt_cause;
    result_t         predicted_q [$];
    int              fail_cnt;

    task automatic clear_string();
        cp_acc     = '0;
        cont_left  = '0;
        four_form  = 1'b0;
        units_out  = '0;
        halted     = 1'b0;
        halt_cause = ST_OK;
    endtask

    // Decode one byte and queue the results it must produce.
    task automatic transcode_byte(input logic [7:0] b, input logic eos);
        logic [15:0] units [2];
        logic [19:0] supp;
        int          n_units;
        int          n_res;
        result_t     r;
        n_units  = 0;
        units[0] = '0;
        units[1] = '0;
        // limit check comes before the byte is looked at
        if (!halted && units_out >= unit_limit)
        begin
            halted     = 1'b1;
            halt_cause = ST_LIMIT;
        end
        if (!halted)
        begin
            if (cont_left != 0)
            begin
                cp_acc    = {cp_acc[CP_W-7:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 0)
                begin
                    if (four_form)
                    begin
                        supp = cp_acc[19:0] - SUPP_OFFSET;
                        if ({1'b0, units_out} + 17'd2 > {1'b0, unit_limit})
                        begin
                            halted     = 1'b1;
                            halt_cause = ST_LIMIT;
                        end
                        else
                        begin
                            units[0] = HI_SURR_BASE | {6'd0, supp[19:10]};
                            units[1] = LO_SURR_BASE | {6'd0, supp[9:0]};
                            n_units  = 2;
                        end
                    end
                    else
                    begin
                        units[0] = cp_acc[15:0];
                        n_units  = 1;
                    end
                    four_form = 1'b0;
                    cp_acc    = '0;
                end
            end
            else if (b[7] == 1'b0)
            begin
                units[0] = {8'd0, b};
                n_units  = 1;
            end
            else if (b[7:5] == 3'b110)
            begin
                cp_acc    = CP_W'(b[4:0]);
                cont_left = 2'd1;
            end
            else if (b[7:4] == 4'b1110)
            begin
                cp_acc    = CP_W'(b[3:0]);
                cont_left = 2'd2;
            end
            else if (b[7:3] == 5'b11110)
            begin
                cp_acc    = CP_W'(b[2:0]);
                cont_left = 2'd3;
                four_form = 1'b1;
            end
            else
            begin
                halted     = 1'b1;
                halt_cause = ST_INVALID;
            end
        end
        units_out = units_out + 16'(n_units);

        n_res = (eos && n_units == 0) ? 1 : n_units;
        for (int k = 0; k < n_res; k++)
        begin
            r.code_unit   = (k < n_units) ? units[k] : '0;
            r.unit_valid  = (k < n_units);
            r.last_of_run = (k == n_res - 1);
            r.string_done = eos && (k == n_res - 1);
            r.status      = ST_OK;
            if (r.string_done)
                r.status = halted ? halt_cause : ((cont_left != 0) ? ST_TRUNC : ST_OK);
            predicted_q = {predicted_q, r};
        end
        if (eos)
            clear_string();
    endtask

    task automatic check_result();
        result_t want;
        result_t got;
        got.code_unit   = m_tdata;
        got.unit_valid  = m_tuser[0];
        got.status      = status_t'(m_tuser[2:1]);
        got.last_of_run = m_tuser[3];
        got.string_done = m_tlast;
        if (predicted_q.size() == 0)
        begin
            fail_cnt++;
            if (fail_cnt <= 10)
                $display("%0t: unexpected result: unit %h valid %b status %0d last %b done %b",
                         $realtime, got.code_unit, got.unit_valid, got.status,
                         got.last_of_run, got.string_done);
        end
        else
        begin
            want = predicted_q.pop_front();
            if (got.code_unit !== want.code_unit || got.unit_valid !== want.unit_valid ||
                got.status !== want.status || got.last_of_run !== want.last_of_run ||
                got.string_done !== want.string_done)
            begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display({"%0t: mismatch: exp unit %h valid %b status %0d last %b done %b",
                              " / got unit %h valid %b status %0d last %b done %b"},
                             $realtime, want.code_unit, want.unit_valid, want.status,
                             want.last_of_run, want.string_done, got.code_unit,
                             got.unit_valid, got.status, got.last_of_run, got.string_done);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_limit = MAX_UNITS_RESET;
            clear_string();
            predicted_q.delete();
            fail_cnt = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_result();
            if (cfg_wr_en)
                unit_limit = cfg_wr_data;
            if (s_tvalid && s_tready)
                transcode_byte(s_tdata, s_tlast);
            mismatches  <= fail_cnt;
            outstanding <= predicted_q.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the UTF-8 to UTF-16 decoder: clock, reset, stimulus, verdict.
module tb_top;
    import u8dec_pkg::*;

    // Settling time after the last predicted result, to cover a byte still in flight.
    localparam int DRAIN_CYCLES = 8;
    // Long receiver hold, long enough to fill the result queue and stall s_tready.
    localparam int LONG_HOLD    = 120;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic [7:0]  s_tdata     = '0;
    logic        s_tlast     = 1'b0;
    logic        m_tready    = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [15:0] m_tdata;
    wire  [3:0]  m_tuser;
    wire         m_tlast;

    int mismatches;
    int outstanding;
    int bytes_sent    = 0;
    int results_taken = 0;
    bit tx_steady     = 1'b0;   // sender offers back to back while set
    bit rx_steady     = 1'b0;   // receiver always ready while set

    utf8_to_utf16_stream_decoder_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    utf16_result_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Offer one byte after a random gap and hold it until the transaction completes.
    // s_tvalid stays high afterwards so back-to-back bytes need no extra edge.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 14);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eos;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
        if ($urandom_range(0, 63) == 0)
            tx_steady = !tx_steady;
    endtask

    // One string: end mark on the final byte.
    task automatic send_string(input logic [7:0] str [$]);
        for (int i = 0; i < str.size(); i++)
            send_byte(str[i], i == str.size() - 1);
    endtask

    // Sender pause: stop offering, wait for every predicted result, then let
    // a byte that causes no result settle inside the block.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Limit register is only written with the block idle and between strings.
    task automatic write_limit(input logic [15:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom)};
    endfunction

    // Mostly well-formed sequences with random payload; some invalid leads,
    // unchecked follow-on bytes, raw noise and strings cut short mid-form.
    task automatic send_random_string();
        logic [7:0] str [$];
        int         n_seq;
        int         kind;
        int         cut;
        n_seq = $urandom_range(1, 10);
        for (int i = 0; i < n_seq; i++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 30)
                str = {str, {1'b0, 7'($urandom)}};
            else if (kind < 50)
            begin
                str = {str, {3'b110, 5'($urandom)}};
                str = {str, cont_byte()};
            end
            else if (kind < 68)
            begin
                str = {str, {4'b1110, 4'($urandom)}};
                repeat (2) str = {str, cont_byte()};
            end
            else if (kind < 85)
            begin
                str = {str, {5'b11110, 3'($urandom)}};
                repeat (3) str = {str, cont_byte()};
            end
            else if (kind < 90)
            begin
                // follow-on byte pattern is not checked by the block
                str = {str, {3'b110, 5'($urandom)}};
                str = {str, 8'($urandom)};
            end
            else if (kind < 95)
                str = {str, ($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                                  : 8'($urandom_range(8'hF8, 8'hFF)))};
            else
                str = {str, 8'($urandom)};
        end
        // occasionally chop the tail so the end mark may land inside a form
        if ($urandom_range(0, 9) == 0 && str.size() > 1)
        begin
            cut = $urandom_range(1, (str.size() > 3) ? 3 : str.size() - 1);
            repeat (cut) void'(str.pop_back());
        end
        send_string(str);
    endtask

    // Result side: random ready gaps, steady stretches, and two long holds
    // while the sender keeps going so the input side backs up.
    initial
    begin : result_sink
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = rx_steady ? 0 : $urandom_range(0, 14);
            if (results_taken == 300 || results_taken == 900)
                gap = LONG_HOLD;
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            results_taken++;
            if ($urandom_range(0, 63) == 0)
                rx_steady = !rx_steady;
        end
    end

    initial
    begin : stimulus
        logic [7:0]  str [$];
        logic [15:0] limit_val;
        int          phase_len;
        int          phase_start;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset limit: every form, lead extremes, overlong 4-byte form with
        // off-pattern follow-on bytes (code point wraps below 0x10000).
        str = '{8'h7F, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hF0, 8'h00, 8'hC0, 8'hFF};
        send_string(str);
        // Invalid lead from the continuation range, alone in its string.
        str = '{8'h80};
        send_string(str);
        // Invalid lead from the top range; the next byte is ignored.
        str = '{8'hFF, 8'h41};
        send_string(str);
        // Zero byte, then end mark inside a 3-byte form: truncated.
        str = '{8'h00, 8'hE2, 8'h82};
        send_string(str);

        // Zero limit: halts before the first byte is looked at.
        write_limit(16'd0);
        str = '{8'h41};
        send_string(str);
        // Limit filled exactly on the last byte closes ok.
        write_limit(16'd2);
        str = '{8'h41, 8'h42};
        send_string(str);
        // Pair that would pass the limit is dropped whole, later byte ignored.
        str = '{8'h41, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h42};
        send_string(str);

        // Random phases over a range of limits, extremes included.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:       limit_val = 16'hFFFF;
                1:       limit_val = 16'd0;
                2:       limit_val = 16'd1;
                3:       limit_val = 16'($urandom_range(2, 8));
                4:       limit_val = 16'($urandom_range(9, 40));
                5:       limit_val = 16'hFFFE;
                6:       limit_val = 16'($urandom);
                default: limit_val = 16'hFFFF;
            endcase
            write_limit(limit_val);
            // with no units allowed every byte is ignored, so keep it short
            phase_len   = (limit_val == 16'd0) ? 20 : 300;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < phase_len)
                send_random_string();
        end

        drain_results();
        if (mismatches == 0 && outstanding == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // Hard stop: far beyond the slowest legal run.
    initial
    begin : watchdog
        #20_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
